// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the mailbox RTL; compiled out under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define TMS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Expression must never be true outside reset.
`define TMS_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define TMS_ASSERT(label, clk, rst, prop, msg)
`define TMS_NEVER(label, clk, rst, expr, msg)
`endif
`endif

// ===== hw/rtl/tms_pkg.sv =====
// Shared types and constants of the tagged mailbox.
package tms_pkg;

  localparam int SLOTS       = 16;
  localparam int IDX_W       = $clog2(SLOTS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int CFG_W       = 5;
  localparam int TAG_W       = 32;
  localparam int DATA_W      = 64;
  localparam int SLOTS_RESET = 16;

  typedef enum logic {
    CMD_SEND = 1'b0,
    CMD_READ = 1'b1
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_STORED = 2'd0,
    ST_FULL   = 2'd1,
    ST_FOUND  = 2'd2,
    ST_NONE   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEND,
    S_READ
  } tms_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic send_step;
    logic read_step;
  } tms_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic send_done;
    logic read_done;
    logic out_free;
  } tms_stat_t;

endpackage

// ===== hw/rtl/tms_in_if.sv =====
// Request channel: command, tag and payload with valid/ready.
interface tms_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [tms_pkg::TAG_W-1:0]   tag;
  logic [tms_pkg::DATA_W-1:0]  payload;

  modport source (output valid, command, tag, payload, input ready);
  modport sink   (input valid, command, tag, payload, output ready);
endinterface

// ===== hw/rtl/tms_out_if.sv =====
// Response channel: status, found tag and found payload with valid/ready.
interface tms_out_if;
  logic                        valid;
  logic                        ready;
  tms_pkg::status_t            status;
  logic [tms_pkg::TAG_W-1:0]   found_tag;
  logic [tms_pkg::DATA_W-1:0]  found_payload;

  modport source (output valid, status, found_tag, found_payload, input ready);
  modport sink   (input valid, status, found_tag, found_payload, output ready);
endinterface

// ===== hw/rtl/tms_datapath.sv =====
// Mailbox datapath: slot storage, presence flags, scan pointer and result register.
`include "assert_macros.svh"
module tms_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [tms_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                       in_command,
  input  logic [tms_pkg::TAG_W-1:0]  in_tag,
  input  logic [tms_pkg::DATA_W-1:0] in_payload,
  input  tms_pkg::tms_cmd_t          cmd,
  output tms_pkg::tms_stat_t         stat,
  tms_out_if.source                  response
);
  import tms_pkg::*;

  logic [CFG_W-1:0]  slots_in_use;
  logic [CNT_W-1:0]  n;
  logic [SLOTS-1:0]  present;
  logic [TAG_W-1:0]  mem_tag  [SLOTS];
  logic [DATA_W-1:0] mem_data [SLOTS];
  logic [IDX_W-1:0]  wptr;
  logic [IDX_W-1:0]  p;
  logic [IDX_W-1:0]  p_wrap;
  logic [IDX_W-1:0]  start;
  logic [CNT_W-1:0]  p_inc;
  logic [CNT_W-1:0]  cnt;
  logic              rd_valid;
  logic [IDX_W-1:0]  rd_idx;
  logic [TAG_W-1:0]  rd_tag;
  logic [DATA_W-1:0] rd_data;
  logic [TAG_W-1:0]  tag_q;
  logic [DATA_W-1:0] data_q;
  logic              out_valid;
  status_t           out_status;
  logic [TAG_W-1:0]  out_tag;
  logic [DATA_W-1:0] out_data;

  logic              send_exhausted;
  logic              send_store;
  logic              read_hit;
  logic              read_exhausted;
  logic              commit;
  status_t           res_status;
  logic [TAG_W-1:0]  res_tag;
  logic [DATA_W-1:0] res_data;

  always_comb begin
    if (int'(slots_in_use) > SLOTS) begin
      n = CNT_W'(SLOTS);
    end else begin
      n = CNT_W'(slots_in_use);
    end
  end

  assign p_inc  = CNT_W'(p) + CNT_W'(1);
  assign p_wrap = (p_inc < n) ? IDX_W'(p_inc) : '0;
  // Restart at slot 0 when the pointer lies outside the window.
  assign start  = (CNT_W'(wptr) < n) ? wptr : '0;

  assign send_exhausted = (cnt == n);
  assign send_store     = !send_exhausted && !present[p];
  assign read_hit       = rd_valid && present[rd_idx] &&
                          ((tag_q == '0) || (rd_tag == tag_q));
  assign read_exhausted = !rd_valid && (cnt == n);

  assign stat.send_done = send_exhausted || !present[p];
  assign stat.read_done = read_hit || read_exhausted;
  assign stat.out_free  = !out_valid || response.ready;

  assign commit = (cmd.send_step && stat.send_done) ||
                  (cmd.read_step && stat.read_done);

  always_comb begin
    res_status = ST_NONE;
    res_tag    = '0;
    res_data   = '0;
    if (cmd.send_step) begin
      res_status = send_store ? ST_STORED : ST_FULL;
    end else if (read_hit) begin
      res_status = ST_FOUND;
      res_tag    = rd_tag;
      res_data   = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= CFG_W'(SLOTS_RESET);
      present      <= '0;
      wptr         <= '0;
      p            <= '0;
      cnt          <= '0;
      rd_valid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        slots_in_use <= cfg_wr_data;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (response.valid && response.ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        cnt      <= '0;
        rd_valid <= 1'b0;
        p        <= (in_command == CMD_READ) ? '0 : start;
      end
      if (cmd.send_step) begin
        if (send_store) begin
          present[p] <= 1'b1;
          wptr       <= p;
        end else if (send_exhausted) begin
          // Full turn: pointer is back at the start slot.
          if (n != '0) begin
            wptr <= p;
          end
        end else begin
          p   <= p_wrap;
          cnt <= cnt + CNT_W'(1);
        end
      end
      if (cmd.read_step) begin
        // Issue the next slot while the previous one is compared.
        if (cnt < n) begin
          rd_valid <= 1'b1;
          p        <= IDX_W'(p_inc);
          cnt      <= cnt + CNT_W'(1);
        end else begin
          rd_valid <= 1'b0;
        end
        if (read_hit) begin
          present[rd_idx] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tag_q  <= in_tag;
      data_q <= in_payload;
    end
    if (cmd.send_step && send_store) begin
      mem_tag[p]  <= tag_q;
      mem_data[p] <= data_q;
    end
    if (cmd.read_step) begin
      rd_tag  <= mem_tag[p];
      rd_data <= mem_data[p];
      rd_idx  <= p;
    end
    if (commit) begin
      out_status <= res_status;
      out_tag    <= res_tag;
      out_data   <= res_data;
    end
  end

  assign response.valid         = out_valid;
  assign response.status        = out_status;
  assign response.found_tag     = out_tag;
  assign response.found_payload = out_data;

  `TMS_NEVER(a_no_overwrite, clk, rst, commit && out_valid && !response.ready, "result overwritten")
  `TMS_ASSERT(a_cnt_in_window, clk, rst, (cmd.send_step || cmd.read_step) |-> (cnt <= n), "scan ran past window")
  `TMS_ASSERT(a_found_frees, clk, rst, (cmd.read_step && read_hit) |=> !present[$past(rd_idx)], "found slot not freed")
endmodule

// ===== hw/rtl/tms_ctrl.sv =====
// Mailbox controller: sequences one send or read scan at a time.
`include "assert_macros.svh"
module tms_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_command,
  output logic                in_ready,
  input  tms_pkg::tms_stat_t  stat,
  output tms_pkg::tms_cmd_t   cmd
);
  import tms_pkg::*;

  tms_state_t state;
  tms_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (in_command == CMD_READ) ? S_READ : S_SEND;
        end
      end
      S_SEND: begin
        if (stat.out_free && stat.send_done) begin
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        if (stat.out_free && stat.read_done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.send_step = 1'b0;
    cmd.read_step = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      // Hold the scan while the result register is still occupied.
      S_SEND: cmd.send_step = stat.out_free;
      S_READ: cmd.read_step = stat.out_free;
      default: in_ready = 1'b0;
    endcase
  end

  `TMS_ASSERT(a_accept_leaves_idle, clk, rst, (in_valid && in_ready) |=> (state != S_IDLE), "accepted transaction not started")
endmodule

// ===== hw/rtl/tagged_mailbox_slots.sv =====
// Top level of the tagged mailbox: controller plus datapath.
//
// A request transaction carries command (0 send, 1 read), tag and payload.
// A send stores the item in the first free slot at or after the write
// pointer, wrapping over the slots in use; a read takes and frees the
// first present slot from slot 0 whose tag matches (tag 0 matches any).
// Every request gives exactly one response transaction with status,
// found_tag and found_payload (the last two zero unless a message was found).
// slots_in_use is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while idle, which the block itself does not enforce.
// One item is worked on at a time, one slot per cycle by the scan pointer.
// A send probes from its start slot until it stores or has probed all n
// slots in use and is full; a read issues slots from slot 0 and compares
// each through the registered slot memory read, giving none when nothing
// matches; with n = 0 a send is full and a read gives none without probing.
// The next request is accepted the cycle after the result is registered,
// even while that result still waits; a response stall holds the scan.
// Reset clears all presence flags, the write pointer and the response valid,
// and sets slots_in_use to 16.
module tagged_mailbox_slots (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [tms_pkg::CFG_W-1:0] cfg_wr_data,
  tms_in_if.sink                    request,
  tms_out_if.source                 response
);
  import tms_pkg::*;

  tms_cmd_t  cmd;
  tms_stat_t stat;
  logic      in_ready;

  assign request.ready = in_ready;

  tms_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (request.valid),
    .in_command (request.command),
    .in_ready   (in_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  tms_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_command  (request.command),
    .in_tag      (request.tag),
    .in_payload  (request.payload),
    .cmd         (cmd),
    .stat        (stat),
    .response    (response)
  );
endmodule

// ===== bench/tb_tagged_mailbox_slots.sv =====
// Self-checking testbench for the tagged mailbox: directed table, random traffic, scoreboard.
module tb_tagged_mailbox_slots;
  timeunit 1ns;
  timeprecision 1ps;

  import tms_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int NPHASES      = 8;
  localparam int PHASE_SLOTS [NPHASES] = '{16, 3, 1, 8, 0, 31, 0, 16};
  localparam int PHASE_ITEMS [NPHASES] = '{100, 90, 60, 100, 20, 100, 90, 100};
  localparam int HOLD_PHASE   = 3;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    status_t             status;
    logic [TAG_W-1:0]    found_tag;
    logic [DATA_W-1:0]   found_payload;
  } reply_t;

  typedef enum logic {
    ROW_CFG,
    ROW_ITEM
  } row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    cmd_code_t           cmd;
    logic [CFG_W-1:0]    slots;
    logic [TAG_W-1:0]    tag;
    logic [DATA_W-1:0]   payload;
    logic                typed;
    reply_t              reply;
  } dir_row_t;

  localparam logic [TAG_W-1:0]  TAG_ONES  = '1;
  localparam logic [DATA_W-1:0] DATA_ONES = '1;
  localparam reply_t NOT_TYPED  = '{ST_STORED, '0, '0};
  localparam reply_t R_STORED   = '{ST_STORED, '0, '0};
  localparam reply_t R_FULL     = '{ST_FULL, '0, '0};
  localparam reply_t R_NONE     = '{ST_NONE, '0, '0};

  localparam int NROWS = 25;
  localparam dir_row_t DIRECTED_ROWS [NROWS] = '{
    '{ROW_ITEM, CMD_READ, 5'd0, 32'h0, 64'h0, 1'b1, R_NONE},
    '{ROW_ITEM, CMD_SEND, 5'd0, TAG_ONES, DATA_ONES, 1'b1, R_STORED},
    '{ROW_ITEM, CMD_SEND, 5'd0, 32'h0, 64'h0, 1'b1, R_STORED},
    '{ROW_ITEM, CMD_READ, 5'd0, TAG_ONES, 64'h0, 1'b1, '{ST_FOUND, TAG_ONES, DATA_ONES}},
    '{ROW_ITEM, CMD_READ, 5'd0, 32'h1234_5678, DATA_ONES, 1'b0, NOT_TYPED},
    '{ROW_ITEM, CMD_READ, 5'd0, 32'h0, 64'h0, 1'b1, '{ST_FOUND, 32'h0, 64'h0}},
    '{ROW_CFG, CMD_SEND, 5'd2, 32'h0, 64'h0, 1'b0, NOT_TYPED},
    '{ROW_ITEM, CMD_SEND, 5'd0, 32'hA5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, NOT_TYPED},
    '{ROW_ITEM, CMD_SEND, 5'd0, 32'h1, 64'h1, 1'b0, NOT_TYPED},
    '{ROW_ITEM, CMD_SEND, 5'd0, 32'h2, 64'h2, 1'b1, R_FULL},
    '{ROW_ITEM, CMD_READ, 5'd0, 32'h1, 64'h0, 1'b0, NOT_TYPED},
    '{ROW_CFG, CMD_SEND, 5'd1, 32'h0, 64'h0, 1'b0, NOT_TYPED},
    '{ROW_ITEM, CMD_READ, 5'd0, 32'h0, 64'h0, 1'b0, NOT_TYPED},
    '{ROW_ITEM, CMD_SEND, 5'd0, 32'h8000_0000, 64'h8000_0000_0000_0000, 1'b0, NOT_TYPED},
    '{ROW_ITEM, CMD_SEND, 5'd0, 32'h3, 64'h3, 1'b1, R_FULL},
    '{ROW_CFG, CMD_SEND, 5'd0, 32'h0, 64'h0, 1'b0, NOT_TYPED},
    '{ROW_ITEM, CMD_SEND, 5'd0, 32'h4, 64'h4, 1'b1, R_FULL},
    '{ROW_ITEM, CMD_READ, 5'd0, 32'h0, 64'h0, 1'b1, R_NONE},
    '{ROW_CFG, CMD_SEND, 5'd31, 32'h0, 64'h0, 1'b0, NOT_TYPED},
    '{ROW_ITEM, CMD_READ, 5'd0, 32'h0, 64'h0, 1'b0, NOT_TYPED},
    '{ROW_ITEM, CMD_READ, 5'd0, 32'h0, 64'h0, 1'b0, NOT_TYPED},
    '{ROW_CFG, CMD_SEND, 5'd17, 32'h0, 64'h0, 1'b0, NOT_TYPED},
    '{ROW_ITEM, CMD_SEND, 5'd0, 32'h7, 64'h0123_4567_89AB_CDEF, 1'b0, NOT_TYPED},
    '{ROW_ITEM, CMD_READ, 5'd0, 32'h7, 64'h0, 1'b0, NOT_TYPED},
    '{ROW_CFG, CMD_SEND, 5'd16, 32'h0, 64'h0, 1'b0, NOT_TYPED}
  };

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  tms_in_if  request_ch ();
  tms_out_if response_ch ();

  tagged_mailbox_slots i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .request     (request_ch),
    .response    (response_ch)
  );

  // Mailbox shadow state
  logic                slot_busy     [SLOTS];
  logic [TAG_W-1:0]    slot_tag_copy [SLOTS];
  logic [DATA_W-1:0]   slot_data_copy[SLOTS];
  logic [IDX_W-1:0]    send_ptr;
  logic [CFG_W-1:0]    slots_cfg;

  reply_t              pending_replies[$];
  logic [TAG_W-1:0]    tag_pool[8];
  int                  fail_count;
  int                  cycle_count;
  bit                  jitter_on;
  bit                  hold_req;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Advance the shadow mailbox by one request and return its reply.
  function automatic reply_t mailbox_step(cmd_code_t cmd, logic [TAG_W-1:0] tag,
                                          logic [DATA_W-1:0] payload);
    reply_t      r;
    int unsigned n;
    int unsigned p;
    int unsigned i;
    bit          hit;
    r.status        = ST_NONE;
    r.found_tag     = '0;
    r.found_payload = '0;
    n   = (slots_cfg > SLOTS) ? SLOTS : slots_cfg;
    hit = 1'b0;
    if (cmd == CMD_SEND) begin
      r.status = ST_FULL;
      if (n > 0) begin
        p = (send_ptr < n) ? send_ptr : 0;
        for (i = 0; i < n && !hit; i++) begin
          if (!slot_busy[p]) begin
            slot_busy[p]      = 1'b1;
            slot_tag_copy[p]  = tag;
            slot_data_copy[p] = payload;
            r.status          = ST_STORED;
            hit               = 1'b1;
          end else begin
            p = (p + 1 < n) ? p + 1 : 0;
          end
        end
        send_ptr = p[IDX_W-1:0];
      end
    end else begin
      for (i = 0; i < n && !hit; i++) begin
        if (slot_busy[i] && (tag == '0 || slot_tag_copy[i] == tag)) begin
          r.status        = ST_FOUND;
          r.found_tag     = slot_tag_copy[i];
          r.found_payload = slot_data_copy[i];
          slot_busy[i]    = 1'b0;
          hit             = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic offer_request(input cmd_code_t cmd, input logic [TAG_W-1:0] tag,
                               input logic [DATA_W-1:0] payload, input logic typed,
                               input reply_t typed_reply);
    reply_t predicted;
    @(negedge clk);
    request_ch.valid   = 1'b1;
    request_ch.command = cmd;
    request_ch.tag     = tag;
    request_ch.payload = payload;
    @(posedge clk);
    while (!request_ch.ready) @(posedge clk);
    predicted = mailbox_step(cmd, tag, payload);
    pending_replies.push_back(typed ? typed_reply : predicted);
    if (jitter_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      request_ch.valid = 1'b0;
      repeat (pick_gap()) @(negedge clk);
    end
  endtask

  // Drop valid and wait until every outstanding reply has drained.
  task automatic settle_idle();
    @(negedge clk);
    request_ch.valid = 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic apply_slot_count(input logic [CFG_W-1:0] value);
    settle_idle();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    slots_cfg   = value;
  endtask

  task automatic run_traffic(input int count, input bit with_hold);
    cmd_code_t         cmd;
    logic [TAG_W-1:0]  tag;
    int                r;
    for (int k = 0; k < count; k++) begin
      if (with_hold && k == 10) hold_req = 1'b1;
      cmd = ($urandom_range(0, 99) < 52) ? CMD_SEND : CMD_READ;
      r   = $urandom_range(0, 99);
      if (r < 12) tag = '0;
      else if (r < 80) tag = tag_pool[$urandom_range(0, 7)];
      else begin
        tag = $urandom;
        if (cmd == CMD_SEND && $urandom_range(0, 1) == 0)
          tag_pool[$urandom_range(0, 7)] = tag;
      end
      offer_request(cmd, tag, {$urandom, $urandom}, 1'b0, NOT_TYPED);
    end
  endtask

  // Receiver: random back-pressure plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left        = 0;
    response_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        response_ch.ready = 1'b0;
        stall_left--;
      end else begin
        response_ch.ready = 1'b1;
        if (jitter_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && response_ch.valid && response_ch.ready) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected response transaction: status %0d", response_ch.status);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        if (response_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, response_ch.status);
          fail_count++;
        end
        if (response_ch.found_tag !== want.found_tag) begin
          $error("found_tag: expected %h, got %h", want.found_tag, response_ch.found_tag);
          fail_count++;
        end
        if (response_ch.found_payload !== want.found_payload) begin
          $error("found_payload: expected %h, got %h", want.found_payload,
                 response_ch.found_payload);
          fail_count++;
        end
      end
    end
  end

  initial begin
    dir_row_t row;
    int       slots_now;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    request_ch.valid   = 1'b0;
    request_ch.command = CMD_SEND;
    request_ch.tag     = '0;
    request_ch.payload = '0;
    rst                = 1'b1;
    jitter_on          = 1'b0;
    hold_req           = 1'b0;
    fail_count         = 0;
    cycle_count        = 0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_busy[i]      = 1'b0;
      slot_tag_copy[i]  = '0;
      slot_data_copy[i] = '0;
    end
    send_ptr  = '0;
    slots_cfg = SLOTS_RESET;
    // A few small tags keep reads hitting; the rest come and go with traffic.
    for (int i = 0; i < 8; i++) tag_pool[i] = (i < 4) ? i + 1 : $urandom;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < NROWS; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_CFG) apply_slot_count(row.slots);
      else offer_request(row.cmd, row.tag, row.payload, row.typed, row.reply);
    end

    for (int ph = 0; ph < NPHASES; ph++) begin
      slots_now = (ph == 6) ? $urandom_range(1, SLOTS) : PHASE_SLOTS[ph];
      apply_slot_count(slots_now[CFG_W-1:0]);
      jitter_on = (ph != 0);
      run_traffic(PHASE_ITEMS[ph], ph == HOLD_PHASE);
    end

    settle_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
